/* rtl/owrs_pkg.sv */
// Shared types and constants of the 1-Wire ROM search engine.
// No dependencies; every other file of the block uses this package.
`timescale 1ns / 1ps
`default_nettype none

package owrs_pkg;

  localparam int ID_W            = 64;  // width of the rom_id field
  localparam int ROM_ID_BITS_DEF = 64;
  localparam logic [7:0] CRC_POLY    = 8'h8c;  // reflected Dallas CRC-8
  localparam logic [3:0] FAILS_RESET = 4'd10;
  localparam logic [3:0] FAILS_MAX   = 4'd15;

  // result queue
  localparam int QDEPTH  = 8;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);
  localparam int MAX_RES = 3;

  typedef enum logic [1:0] {
    MODE_START    = 2'd0,
    MODE_PRESENCE = 2'd1,
    MODE_PAIR     = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_PRESENCE = 2'd1,
    PH_BITS     = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    K_WRITE = 3'd0,
    K_FOUND = 3'd1,
    K_DONE  = 3'd2,
    K_RETRY = 3'd3,
    K_ERROR = 3'd4
  } result_kind_t;

  typedef struct packed {
    result_kind_t      kind;
    logic              write_bit;
    logic [ID_W-1:0]   rom_id;
    logic              last;
  } result_t;

  typedef struct packed {
    logic [1:0]           cnt;
    result_t [MAX_RES-1:0] res;
  } push_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              room;
  } qstat_t;

endpackage

`default_nettype wire

/* rtl/owrs_engine.sv */
// Search engine: item register, search state and the per-item decision logic.
// Depends on owrs_pkg; pushes up to three results per item into owrs_queue.
`timescale 1ns / 1ps
`default_nettype none

module owrs_engine #(
  parameter int ROM_ID_BITS = owrs_pkg::ROM_ID_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_mode,
  input  wire logic               in_presence,
  input  wire logic               in_id_bit,
  input  wire logic               in_cmp_bit,
  input  wire logic [3:0]         max_fails,
  input  wire logic               room,
  output owrs_pkg::push_t         push
);

  localparam int POS_W = $clog2(ROM_ID_BITS + 1);
  localparam int IDX_W = $clog2(ROM_ID_BITS);
  localparam logic [POS_W-1:0] POS_NONE = POS_W'(ROM_ID_BITS);
  localparam logic [POS_W-1:0] POS_END  = POS_W'(ROM_ID_BITS - 1);

  // item register
  logic       item_valid_r, item_valid_nxt;
  logic [1:0] mode_r;
  logic       pres_r, idb_r, cmp_r;

  // search state
  owrs_pkg::phase_t         phase_r, phase_nxt;
  logic [ROM_ID_BITS-1:0]   prev_id_r, prev_id_nxt;
  logic                     prev_none_r, prev_none_nxt;
  logic [POS_W-1:0]         prev_disc_r, prev_disc_nxt;
  logic [ROM_ID_BITS-1:0]   cur_id_r, cur_id_nxt;
  logic [POS_W-1:0]         cur_disc_r, cur_disc_nxt;
  logic [POS_W-1:0]         pos_r, pos_nxt;
  logic [7:0]               crc_r, crc_nxt;
  logic [3:0]               fails_r, fails_nxt;

  logic                     fire;
  logic                     pair_ok, both_one, both_zero, take_one, dir;
  logic                     end_pass, crc_ok, disc_none, too_many;
  logic [ROM_ID_BITS-1:0]   id_set;
  logic [7:0]               crc_step;
  logic [POS_W-1:0]         disc_step;
  logic [4:0]               fail_inc;

  assign in_ready = !item_valid_r || room;
  assign fire     = item_valid_r && room;

  always_comb begin
    item_valid_nxt = item_valid_r;
    if (in_valid && in_ready) begin
      item_valid_nxt = 1'b1;
    end else if (fire) begin
      item_valid_nxt = 1'b0;
    end
  end

  // shared bit-pair decisions
  assign pair_ok   = (phase_r == owrs_pkg::PH_BITS) && (pos_r < POS_NONE);
  assign both_one  = idb_r && cmp_r;
  assign both_zero = !idb_r && !cmp_r;
  assign take_one  = !prev_none_r &&
                     ((pos_r == prev_disc_r) ||
                      ((pos_r < prev_disc_r) && prev_id_r[pos_r[IDX_W-1:0]]));
  assign dir       = both_zero ? take_one : idb_r;
  assign disc_step = (both_zero && !take_one) ? pos_r : cur_disc_r;

  always_comb begin
    id_set = cur_id_r;
    id_set[pos_r[IDX_W-1:0]] = cur_id_r[pos_r[IDX_W-1:0]] | dir;
  end

  assign crc_step  = {1'b0, crc_r[7:1]} ^ (((crc_r[0] ^ dir)) ? owrs_pkg::CRC_POLY : 8'h00);
  assign end_pass  = (pos_r == POS_END);
  assign crc_ok    = (crc_step == 8'h00);
  assign disc_none = (disc_step >= POS_NONE);
  assign fail_inc  = {1'b0, fails_r} + 5'd1;
  assign too_many  = fail_inc > {1'b0, max_fails};

  // phase transitions
  always_comb begin
    phase_nxt = phase_r;
    if (fire) begin
      unique case (mode_r)
        owrs_pkg::MODE_START: begin
          phase_nxt = owrs_pkg::PH_PRESENCE;
        end
        owrs_pkg::MODE_PRESENCE: begin
          if (phase_r == owrs_pkg::PH_PRESENCE) begin
            phase_nxt = pres_r ? owrs_pkg::PH_BITS : owrs_pkg::PH_IDLE;
          end
        end
        owrs_pkg::MODE_PAIR: begin
          if (pair_ok) begin
            if (both_one) begin
              phase_nxt = owrs_pkg::PH_IDLE;
            end else if (end_pass) begin
              if (crc_ok) begin
                phase_nxt = disc_none ? owrs_pkg::PH_IDLE : owrs_pkg::PH_PRESENCE;
              end else begin
                phase_nxt = too_many ? owrs_pkg::PH_IDLE : owrs_pkg::PH_PRESENCE;
              end
            end
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  // datapath state and results
  always_comb begin
    prev_id_nxt   = prev_id_r;
    prev_none_nxt = prev_none_r;
    prev_disc_nxt = prev_disc_r;
    cur_id_nxt    = cur_id_r;
    cur_disc_nxt  = cur_disc_r;
    pos_nxt       = pos_r;
    crc_nxt       = crc_r;
    fails_nxt     = fails_r;
    push          = '0;
    if (fire) begin
      unique case (mode_r)
        owrs_pkg::MODE_START: begin
          prev_id_nxt   = '0;
          prev_none_nxt = 1'b1;
          fails_nxt     = 4'd0;
        end
        owrs_pkg::MODE_PRESENCE: begin
          if (phase_r == owrs_pkg::PH_PRESENCE) begin
            if (!pres_r) begin
              push.cnt         = 2'd1;
              push.res[0].kind = owrs_pkg::K_DONE;
            end else begin
              cur_id_nxt   = '0;
              cur_disc_nxt = POS_NONE;
              pos_nxt      = '0;
              crc_nxt      = 8'h00;
            end
          end
        end
        owrs_pkg::MODE_PAIR: begin
          if (pair_ok) begin
            if (both_one) begin
              push.cnt         = 2'd1;
              push.res[0].kind = owrs_pkg::K_DONE;
            end else begin
              cur_id_nxt   = id_set;
              cur_disc_nxt = disc_step;
              crc_nxt      = crc_step;
              pos_nxt      = pos_r + POS_W'(1);
              push.cnt              = 2'd1;
              push.res[0].kind      = owrs_pkg::K_WRITE;
              push.res[0].write_bit = dir;
              if (end_pass) begin
                push.cnt = 2'd2;
                if (crc_ok) begin
                  prev_id_nxt           = id_set;
                  prev_none_nxt         = 1'b0;
                  prev_disc_nxt         = disc_step;
                  push.res[1].kind      = owrs_pkg::K_FOUND;
                  push.res[1].rom_id    = owrs_pkg::ID_W'(id_set);
                  if (disc_none) begin
                    push.cnt         = 2'd3;
                    push.res[2].kind = owrs_pkg::K_DONE;
                  end
                end else begin
                  fails_nxt = fail_inc[4] ? owrs_pkg::FAILS_MAX : fail_inc[3:0];
                  if (too_many) begin
                    push.res[1].kind = owrs_pkg::K_ERROR;
                  end else begin
                    push.res[1].kind      = owrs_pkg::K_RETRY;
                    push.res[1].rom_id    = owrs_pkg::ID_W'(id_set);
                  end
                end
              end
            end
          end
        end
        default: begin
          push.cnt = 2'd0;
        end
      endcase
    end
    // mark the final result of this item
    for (int i = 0; i < owrs_pkg::MAX_RES; i++) begin
      push.res[i].last = (push.cnt == 2'(i + 1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      phase_r      <= owrs_pkg::PH_IDLE;
      prev_id_r    <= '0;
      prev_none_r  <= 1'b1;
      prev_disc_r  <= '0;
      cur_id_r     <= '0;
      cur_disc_r   <= POS_NONE;
      pos_r        <= '0;
      crc_r        <= 8'h00;
      fails_r      <= 4'd0;
    end else begin
      item_valid_r <= item_valid_nxt;
      phase_r      <= phase_nxt;
      prev_id_r    <= prev_id_nxt;
      prev_none_r  <= prev_none_nxt;
      prev_disc_r  <= prev_disc_nxt;
      cur_id_r     <= cur_id_nxt;
      cur_disc_r   <= cur_disc_nxt;
      pos_r        <= pos_nxt;
      crc_r        <= crc_nxt;
      fails_r      <= fails_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mode_r <= in_mode;
      pres_r <= in_presence;
      idb_r  <= in_id_bit;
      cmp_r  <= in_cmp_bit;
    end
  end

endmodule

`default_nettype wire

/* rtl/owrs_queue.sv */
// Result queue: takes up to three results a cycle, hands out one per cycle while out_ready is high.
// Depends on owrs_pkg for the result and push types.
`timescale 1ns / 1ps
`default_nettype none

module owrs_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  owrs_pkg::push_t        push,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output owrs_pkg::result_t      out_res,
  output owrs_pkg::qstat_t       stat
);

  owrs_pkg::result_t mem_r [owrs_pkg::QDEPTH];
  logic [owrs_pkg::QPTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [owrs_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;
  logic                        pop;

  assign out_valid  = (cnt_r != '0);
  assign out_res    = mem_r[rp_r];
  assign pop        = out_valid && out_ready;
  assign stat.count = cnt_r;
  // room for a full three-result burst
  assign stat.room  = cnt_r <= owrs_pkg::QCNT_W'(owrs_pkg::QDEPTH - owrs_pkg::MAX_RES);

  assign wp_nxt  = wp_r + owrs_pkg::QPTR_W'(push.cnt);
  assign rp_nxt  = rp_r + owrs_pkg::QPTR_W'(pop);
  assign cnt_nxt = cnt_r + owrs_pkg::QCNT_W'(push.cnt) - owrs_pkg::QCNT_W'(pop);

  always_ff @(posedge clk) begin
    for (int i = 0; i < owrs_pkg::MAX_RES; i++) begin
      if (2'(i) < push.cnt) begin
        mem_r[wp_r + owrs_pkg::QPTR_W'(i)] <= push.res[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/onewire_rom_search_top.sv */
// 1-Wire ROM search engine, top level: configuration register and stream ports.
// Depends on owrs_pkg, owrs_engine and owrs_queue.
//
// Usage:
//   The input stream carries one request per bus event: start a search, the
//   presence result of a bus reset, or one received id/complement bit pair
//   (in_tuser selects which). The output stream returns the results of each
//   request in order: direction bits to write back, found device ids, search
//   finished, checksum retry passes and the checksum error; out_tlast marks
//   the final result of one request. Requests that cause nothing give nothing.
//   An accepted request is held in the item register until the queue has room;
//   the search logic then works on it and writes its results into the queue
//   registers, from which the first result is offered to the receiver.
//   Throughput: one request per cycle while the queue has room. The output
//   drains one result per cycle while out_tready is high, from an eight-entry
//   queue; in_tready drops only while the queue lacks room for the three
//   results a single bit pair can cause, so a stalled receiver backs up into
//   the input after a few requests and loses nothing.
//   Reset (rst_n low at a clock edge) empties the queue, puts the engine idle
//   with no previous id or discrepancy and sets max_checksum_fails to 10.
//   Write max_checksum_fails by cfg_we only while the block is idle; not enforced.
`timescale 1ns / 1ps
`default_nettype none

module onewire_rom_search_top #(
  parameter int ROM_ID_BITS = owrs_pkg::ROM_ID_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration: max_checksum_fails
  input  wire logic        cfg_we,
  input  wire logic [3:0]  cfg_wdata,
  // input requests
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [0] presence, [1] id_bit, [2] complement_bit
  input  wire logic [1:0]  in_tuser,   // [1:0] mode
  // results
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [71:0]      out_tdata,  // [0] write_bit, [64:1] rom_id
  output logic [2:0]       out_tuser,  // [2:0] result_kind
  output logic             out_tlast
);

  logic [3:0]         max_fails_r, max_fails_nxt;
  owrs_pkg::push_t    push;
  owrs_pkg::qstat_t   qstat;
  owrs_pkg::result_t  res;

  // hold the fail limit until written
  assign max_fails_nxt = cfg_we ? cfg_wdata : max_fails_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_fails_r <= owrs_pkg::FAILS_RESET;
    end else begin
      max_fails_r <= max_fails_nxt;
    end
  end

  owrs_engine #(
    .ROM_ID_BITS (ROM_ID_BITS)
  ) u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_mode     (in_tuser),
    .in_presence (in_tdata[0]),
    .in_id_bit   (in_tdata[1]),
    .in_cmp_bit  (in_tdata[2]),
    .max_fails   (max_fails_r),
    .room        (qstat.room),
    .push        (push)
  );

  owrs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res),
    .stat      (qstat)
  );

  // pack the result; pad the upper seven bits with zeros
  assign out_tdata = {7'b0, res.rom_id, res.write_bit};
  assign out_tuser = res.kind;
  assign out_tlast = res.last;

  // queue never overfills
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    qstat.count <= owrs_pkg::QCNT_W'(owrs_pkg::QDEPTH))
    else $error("result queue overfilled");

  // retry and error always close the results of a request
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == owrs_pkg::K_RETRY || out_tuser == owrs_pkg::K_ERROR)
    |-> out_tlast)
    else $error("retry or error result not marked last");

  // finished and error carry no id and no direction bit
  a_empty_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == owrs_pkg::K_DONE || out_tuser == owrs_pkg::K_ERROR)
    |-> (out_tdata == '0))
    else $error("status result carries payload");

  // a direction bit never carries an id
  a_write_no_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == owrs_pkg::K_WRITE |-> (out_tdata[71:1] == '0))
    else $error("write result carries an id");

endmodule

`default_nettype wire

/* tb/tb_onewire_rom_search_top.sv */
// Self-checking testbench for the 1-Wire ROM search engine top level.
// Drives search, presence and bit-pair requests from simulated bus devices and
// checks every result against a behavioral engine; needs owrs_pkg and the top.
`timescale 1ns / 1ps

module tb_onewire_rom_search_top;

  localparam int ID_BITS      = 64;
  localparam int IDLE_PCT     = 21;   // chance per cycle that a side idles
  localparam int NOISE_PCT    = 6;    // stray requests mixed into the searches
  localparam int BAD_PASS_PCT = 20;   // passes fed with garbage bits (bad CRC)
  localparam int HOLD_OFF     = 400;  // receiver stall that backs up the input
  localparam int SETTLE       = 8;    // cycles for a request still in flight
  localparam int CYCLE_LIMIT  = 200000;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [3:0]  cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [0] presence, [1] id_bit, [2] complement_bit
  logic [1:0]  in_tuser;   // [1:0] mode
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;  // [0] write_bit, [64:1] rom_id
  logic [2:0]  out_tuser;  // [2:0] result_kind
  logic        out_tlast;

  onewire_rom_search_top #(
    .ROM_ID_BITS(ID_BITS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Behavioral copy of the search engine: register and search state.
  logic [3:0]  fail_limit;
  logic [63:0] last_found_id;   // id of the previous successful pass
  int          last_fork;       // discrepancy of that pass, -1 for none
  logic [63:0] rom_bits;        // id assembled in the current pass
  int          new_fork;        // last zero-branch taken in this pass
  int          bit_idx;
  logic [7:0]  crc_acc;
  logic [3:0]  crc_fails;
  owrs_pkg::phase_t search_phase;

  owrs_pkg::result_t step_out[$];     // results of the request just accepted
  owrs_pkg::result_t results_due[$];  // results still owed by the block
  int      bad_results;
  int      checked;

  // Simulated bus: a few devices with valid CRCs answer the bit reads.
  logic [63:0] dev_ids[4];
  int          dev_count;
  logic [3:0]  live_mask;       // devices still matching the path taken
  bit          garbage_pass;

  bit quiet;                    // no idling on either side
  int hold_off_asks;

  function automatic logic [7:0] crc8_shift(input logic [7:0] c, input logic b);
    crc8_shift = (c >> 1) ^ ((c[0] ^ b) ? owrs_pkg::CRC_POLY : 8'h00);
  endfunction

  function automatic void emit_result(input owrs_pkg::result_kind_t k, input logic w,
                                      input logic [63:0] id);
    owrs_pkg::result_t r;
    r.kind      = k;
    r.write_bit = w;
    r.rom_id    = id;
    r.last      = 1'b0;
    step_out    = {step_out, r};
  endfunction

  // Advance the behavioral engine by one accepted request.
  task automatic step_search(input logic [1:0] mode, input logic pres, idb, cmp);
    logic dir;
    int   tally;
    step_out.delete();
    case (mode)
      owrs_pkg::MODE_START: begin
        last_found_id = '0;
        last_fork     = -1;
        crc_fails     = '0;
        search_phase  = owrs_pkg::PH_PRESENCE;
      end
      owrs_pkg::MODE_PRESENCE: begin
        if (search_phase == owrs_pkg::PH_PRESENCE) begin
          if (!pres) begin
            search_phase = owrs_pkg::PH_IDLE;
            emit_result(owrs_pkg::K_DONE, 1'b0, '0);
          end else begin
            rom_bits     = '0;
            new_fork     = ID_BITS;
            bit_idx      = 0;
            crc_acc      = '0;
            search_phase = owrs_pkg::PH_BITS;
          end
        end
      end
      owrs_pkg::MODE_PAIR: begin
        if (search_phase == owrs_pkg::PH_BITS && bit_idx < ID_BITS) begin
          if (idb && cmp) begin
            // nobody answered: the search is over
            search_phase = owrs_pkg::PH_IDLE;
            emit_result(owrs_pkg::K_DONE, 1'b0, '0);
          end else begin
            dir = idb;
            if (!idb && !cmp) begin
              // devices disagree: follow the previous path or branch to zero
              if (bit_idx == last_fork || (bit_idx < last_fork && last_found_id[bit_idx]))
                dir = 1'b1;
              else begin
                dir      = 1'b0;
                new_fork = bit_idx;
              end
            end
            emit_result(owrs_pkg::K_WRITE, dir, '0);
            if (dir) rom_bits[bit_idx] = 1'b1;
            crc_acc = crc8_shift(crc_acc, dir);
            bit_idx++;
            if (bit_idx >= ID_BITS) begin
              if (crc_acc == 8'h00) begin
                last_found_id = rom_bits;
                last_fork     = new_fork;
                emit_result(owrs_pkg::K_FOUND, 1'b0, rom_bits);
                if (new_fork >= ID_BITS) begin
                  search_phase = owrs_pkg::PH_IDLE;
                  emit_result(owrs_pkg::K_DONE, 1'b0, '0);
                end else
                  search_phase = owrs_pkg::PH_PRESENCE;
              end else begin
                tally     = int'(crc_fails) + 1;
                crc_fails = (tally > 15) ? owrs_pkg::FAILS_MAX : 4'(tally);
                if (tally > int'(fail_limit)) begin
                  search_phase = owrs_pkg::PH_IDLE;
                  emit_result(owrs_pkg::K_ERROR, 1'b0, '0);
                end else begin
                  search_phase = owrs_pkg::PH_PRESENCE;
                  emit_result(owrs_pkg::K_RETRY, 1'b0, rom_bits);
                end
              end
            end
          end
        end
      end
      default: ;
    endcase
    if (step_out.size() != 0) step_out[step_out.size() - 1].last = 1'b1;
  endtask

  // Offer one request, wait for it to be taken, then predict its results.
  // Entered and left at a falling edge.
  task automatic send_request(input logic [1:0] mode, input logic pres, idb, cmp,
                              input bit typed);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = mode;
    in_tdata  = {5'd0, cmp, idb, pres};
    do @(posedge clk); while (!in_tready);
    step_search(mode, pres, idb, cmp);
    if (!typed) foreach (step_out[j]) results_due = {results_due, step_out[j]};
    @(negedge clk);
  endtask

  // Stop offering, wait for every owed result and let stray requests settle.
  task automatic drain_results();
    in_tvalid = 1'b0;
    while (results_due.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_fail_limit(input logic [3:0] v);
    drain_results();
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we     = 1'b0;
    fail_limit = v;
  endtask

  // Run searches over the simulated bus, with garbage passes and stray requests.
  task automatic random_phase(input int n_reqs);
    int          sent;
    logic [1:0]  mode;
    logic        pres, idb, cmp, all_one, all_zero;
    logic [63:0] base;
    logic [55:0] payload;
    logic [7:0]  c;
    owrs_pkg::phase_t phase_was;
    int          pos_was;
    sent = 0;
    while (sent < n_reqs) begin
      pres = 1'($urandom_range(1));
      idb  = 1'($urandom_range(1));
      cmp  = 1'($urandom_range(1));
      if ($urandom_range(99) < NOISE_PCT)
        mode = 2'($urandom_range(3));
      else begin
        sent++;
        case (search_phase)
          owrs_pkg::PH_IDLE: begin
            // new search over a fresh set of devices sharing most id bits
            mode      = owrs_pkg::MODE_START;
            dev_count = $urandom_range(4, 1);
            base      = {$urandom, $urandom};
            for (int i = 0; i < dev_count; i++) begin
              payload = base[55:0] ^ (56'd1 << $urandom_range(55));
              if ($urandom_range(1) == 1) payload ^= 56'd1 << $urandom_range(55);
              c = 8'h00;
              for (int k = 0; k < 56; k++) c = crc8_shift(c, payload[k]);
              dev_ids[i] = {c, payload};
            end
          end
          owrs_pkg::PH_PRESENCE: begin
            mode = owrs_pkg::MODE_PRESENCE;
            pres = ($urandom_range(99) >= 4);
          end
          default: begin
            mode = owrs_pkg::MODE_PAIR;
            if (garbage_pass) begin
              if ($urandom_range(99) < 10) begin
                idb = 1'b0;
                cmp = 1'b0;
              end else
                cmp = ~idb;
            end else begin
              // wired-AND of the live devices' bit and its complement
              all_one  = 1'b1;
              all_zero = 1'b1;
              for (int i = 0; i < dev_count; i++) begin
                if (live_mask[i]) begin
                  all_one  &= dev_ids[i][bit_idx];
                  all_zero &= ~dev_ids[i][bit_idx];
                end
              end
              idb = all_one;
              cmp = all_zero;
            end
          end
        endcase
      end
      phase_was = search_phase;
      pos_was   = bit_idx;
      send_request(mode, pres, idb, cmp, 1'b0);
      if (phase_was == owrs_pkg::PH_PRESENCE && search_phase == owrs_pkg::PH_BITS) begin
        live_mask    = 4'((1 << dev_count) - 1);
        garbage_pass = ($urandom_range(99) < BAD_PASS_PCT);
      end
      // drop devices that disagree with the direction written back
      foreach (step_out[j]) begin
        if (step_out[j].kind == owrs_pkg::K_WRITE) begin
          for (int i = 0; i < 4; i++)
            if (dev_ids[i][pos_was] != step_out[j].write_bit) live_mask[i] = 1'b0;
        end
      end
    end
  endtask

  typedef struct packed {
    logic [1:0]   mode;
    logic         pres;
    logic         idb;
    logic         cmp;
    logic [6:0]   reps;     // same request sent this many times
    logic         typed;    // result below is exact; otherwise predict it
    logic         has_res;
    owrs_pkg::result_kind_t kind;
    logic         wbit;
  } opening_req_t;

  localparam opening_req_t OPENING_REQS [27] = '{
    // requests in the wrong phase or with the unused mode are dropped; a start gives no result
    '{owrs_pkg::MODE_PAIR,     1'b0, 1'b0, 1'b1, 7'd1,  1'b1, 1'b0, owrs_pkg::K_WRITE, 1'b0},
    '{owrs_pkg::MODE_PRESENCE, 1'b1, 1'b0, 1'b0, 7'd1,  1'b1, 1'b0, owrs_pkg::K_WRITE, 1'b0},
    '{MODE_UNUSED,             1'b1, 1'b1, 1'b1, 7'd1,  1'b1, 1'b0, owrs_pkg::K_WRITE, 1'b0},
    '{owrs_pkg::MODE_START,    1'b0, 1'b0, 1'b0, 7'd1,  1'b1, 1'b0, owrs_pkg::K_WRITE, 1'b0},
    '{owrs_pkg::MODE_PAIR,     1'b0, 1'b1, 1'b0, 7'd1,  1'b1, 1'b0, owrs_pkg::K_WRITE, 1'b0},
    // nobody on the bus
    '{owrs_pkg::MODE_PRESENCE, 1'b0, 1'b1, 1'b1, 7'd1,  1'b1, 1'b1, owrs_pkg::K_DONE,  1'b0},
    // both reads high ends the search
    '{owrs_pkg::MODE_START,    1'b1, 1'b1, 1'b1, 7'd1,  1'b1, 1'b0, owrs_pkg::K_WRITE, 1'b0},
    '{owrs_pkg::MODE_PRESENCE, 1'b1, 1'b0, 1'b0, 7'd1,  1'b1, 1'b0, owrs_pkg::K_WRITE, 1'b0},
    '{owrs_pkg::MODE_PAIR,     1'b0, 1'b1, 1'b1, 7'd1,  1'b1, 1'b1, owrs_pkg::K_DONE,  1'b0},
    // plain bits, then a discrepancy with no earlier pass: take zero
    '{owrs_pkg::MODE_START,    1'b0, 1'b0, 1'b0, 7'd1,  1'b1, 1'b0, owrs_pkg::K_WRITE, 1'b0},
    '{owrs_pkg::MODE_PRESENCE, 1'b1, 1'b1, 1'b0, 7'd1,  1'b1, 1'b0, owrs_pkg::K_WRITE, 1'b0},
    '{owrs_pkg::MODE_PAIR,     1'b0, 1'b0, 1'b1, 7'd1,  1'b1, 1'b1, owrs_pkg::K_WRITE, 1'b0},
    '{owrs_pkg::MODE_PAIR,     1'b0, 1'b1, 1'b0, 7'd1,  1'b1, 1'b1, owrs_pkg::K_WRITE, 1'b1},
    '{owrs_pkg::MODE_PAIR,     1'b1, 1'b0, 1'b0, 7'd1,  1'b1, 1'b1, owrs_pkg::K_WRITE, 1'b0},
    '{MODE_UNUSED,             1'b0, 1'b0, 1'b0, 7'd1,  1'b1, 1'b0, owrs_pkg::K_WRITE, 1'b0},
    '{owrs_pkg::MODE_PRESENCE, 1'b1, 1'b0, 1'b0, 7'd1,  1'b1, 1'b0, owrs_pkg::K_WRITE, 1'b0},
    // restart mid-pass, then a full pass of the all-zero id (CRC clean)
    '{owrs_pkg::MODE_START,    1'b0, 1'b0, 1'b0, 7'd1,  1'b1, 1'b0, owrs_pkg::K_WRITE, 1'b0},
    '{owrs_pkg::MODE_PRESENCE, 1'b1, 1'b0, 1'b0, 7'd1,  1'b1, 1'b0, owrs_pkg::K_WRITE, 1'b0},
    '{owrs_pkg::MODE_PAIR,     1'b0, 1'b0, 1'b1, 7'd64, 1'b0, 1'b0, owrs_pkg::K_WRITE, 1'b0},
    // all-ones id fails the CRC and asks for a retry pass
    '{owrs_pkg::MODE_START,    1'b0, 1'b0, 1'b0, 7'd1,  1'b1, 1'b0, owrs_pkg::K_WRITE, 1'b0},
    '{owrs_pkg::MODE_PRESENCE, 1'b1, 1'b0, 1'b0, 7'd1,  1'b1, 1'b0, owrs_pkg::K_WRITE, 1'b0},
    '{owrs_pkg::MODE_PAIR,     1'b0, 1'b1, 1'b0, 7'd64, 1'b0, 1'b0, owrs_pkg::K_WRITE, 1'b0},
    // every bit in conflict: zero id found, last fork at the top bit
    '{owrs_pkg::MODE_PRESENCE, 1'b1, 1'b0, 1'b0, 7'd1,  1'b1, 1'b0, owrs_pkg::K_WRITE, 1'b0},
    '{owrs_pkg::MODE_PAIR,     1'b0, 1'b0, 1'b0, 7'd64, 1'b0, 1'b0, owrs_pkg::K_WRITE, 1'b0},
    // next pass follows the earlier path and flips at the fork
    '{owrs_pkg::MODE_PRESENCE, 1'b1, 1'b0, 1'b0, 7'd1,  1'b1, 1'b0, owrs_pkg::K_WRITE, 1'b0},
    '{owrs_pkg::MODE_PAIR,     1'b1, 1'b0, 1'b0, 7'd64, 1'b0, 1'b0, owrs_pkg::K_WRITE, 1'b0},
    '{owrs_pkg::MODE_PRESENCE, 1'b0, 1'b0, 1'b0, 7'd1,  1'b0, 1'b0, owrs_pkg::K_WRITE, 1'b0}
  };

  task automatic flag_result(input string what, input logic [63:0] got,
                             input logic [63:0] want);
    bad_results++;
    $display("result %0d: %s got %h want %h", checked, what, got, want);
  endtask

  // Compare every accepted result with the oldest one owed.
  always @(posedge clk) begin : check_results
    owrs_pkg::result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      checked++;
      if (results_due.size() == 0)
        flag_result("unexpected result, kind", 64'(out_tuser), 64'd0);
      else begin
        want = results_due.pop_front();
        if (out_tuser !== want.kind) flag_result("kind", 64'(out_tuser), 64'(want.kind));
        if (out_tdata[0] !== want.write_bit)
          flag_result("write_bit", 64'(out_tdata[0]), 64'(want.write_bit));
        if (out_tdata[64:1] !== want.rom_id)
          flag_result("rom_id", out_tdata[64:1], want.rom_id);
        if (out_tlast !== want.last) flag_result("last", 64'(out_tlast), 64'(want.last));
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off per request from the sender side.
  initial begin : receiver
    int stall_left;
    int asks_seen;
    out_tready = 1'b0;
    stall_left = 0;
    asks_seen  = 0;
    forever begin
      @(negedge clk);
      if (hold_off_asks != asks_seen) begin
        asks_seen  = hold_off_asks;
        stall_left = HOLD_OFF;
      end
      if (stall_left > 0) begin
        out_tready = 1'b0;
        stall_left--;
      end else
        out_tready = quiet || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Give up on a hung block.
  int cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("onewire_rom_search_top: mismatch");
      $finish;
    end
  end

  initial begin
    owrs_pkg::result_t typed_res;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = 4'd0;
    in_tvalid     = 1'b0;
    in_tdata      = 8'd0;
    in_tuser      = 2'd0;
    quiet         = 1'b0;
    hold_off_asks = 0;
    bad_results   = 0;
    checked       = 0;
    dev_count     = 1;
    live_mask     = 4'd0;
    garbage_pass  = 1'b0;
    foreach (dev_ids[i]) dev_ids[i] = '0;

    // engine state after reset
    fail_limit    = owrs_pkg::FAILS_RESET;
    last_found_id = '0;
    last_fork     = -1;
    rom_bits      = '0;
    new_fork      = ID_BITS;
    bit_idx       = 0;
    crc_acc       = '0;
    crc_fails     = '0;
    search_phase  = owrs_pkg::PH_IDLE;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed requests at the reset limit of ten failures
    foreach (OPENING_REQS[i]) begin
      repeat (OPENING_REQS[i].reps) begin
        send_request(OPENING_REQS[i].mode, OPENING_REQS[i].pres, OPENING_REQS[i].idb,
                     OPENING_REQS[i].cmp, OPENING_REQS[i].typed);
        if (OPENING_REQS[i].typed && OPENING_REQS[i].has_res) begin
          typed_res   = {OPENING_REQS[i].kind, OPENING_REQS[i].wbit, 64'd0, 1'b1};
          results_due = {results_due, typed_res};
        end
      end
    end

    // no failures allowed; the receiver holds off early so the queue fills
    set_fail_limit(4'd0);
    hold_off_asks++;
    random_phase(36);

    // widest limit, both sides at full rate
    set_fail_limit(owrs_pkg::FAILS_MAX);
    quiet = 1'b1;
    random_phase(36);

    set_fail_limit(4'd1);
    quiet = 1'b0;
    random_phase(36);

    set_fail_limit(4'($urandom_range(14, 2)));
    random_phase(36);

    drain_results();
    if (bad_results == 0)
      $display("onewire_rom_search_top: match");
    else
      $display("onewire_rom_search_top: mismatch");
    $finish;
  end

endmodule
